FILE: src/isr_pkg.sv
// Shared types and constants for the 64-bit integer square root block.
package isr_pkg;

    localparam int RADICAND_W = 64;
    localparam int ROOT_W     = 32;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CALC,
        ST_DONE
    } isr_state_t;

    typedef struct packed {
        logic load;      // capture a new radicand, clear the partial root
        logic step;      // one two-bit iteration
        logic publish;   // copy the finished root into the output register
    } isr_cmd_t;

    typedef struct packed {
        logic last_step; // trial bit sits at position zero
    } isr_status_t;

endpackage

FILE: src/integer_square_root_64.sv
// Integer square root, floor(sqrt(x)) of a 64-bit unsigned radicand.
// Sequence: load on the accepting edge, IN_WIDTH/2 rounded up two-bit iterations in a single
// subtract-compare unit (ST_CALC), then hand-off from ST_DONE into the output register.
// One item in flight: a new radicand is accepted only in ST_IDLE, after hand-off; the output
// register holds a result while the next item is accepted; a held result stalls hand-off.
// Reset (rst_n, async, active low) clears control state only.
module integer_square_root_64 #(
    parameter int IN_WIDTH = 64
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [isr_pkg::RADICAND_W-1:0]  s_axis_tdata,   // [63:0] radicand
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [isr_pkg::ROOT_W-1:0]      m_axis_tdata    // [31:0] root
);
    import isr_pkg::*;

    isr_cmd_t    cmd;
    isr_status_t status;

    isr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .status    (status),
        .cmd       (cmd)
    );

    isr_datapath #(
        .IN_WIDTH (IN_WIDTH)
    ) u_datapath (
        .clk      (clk),
        .radicand (s_axis_tdata),
        .cmd      (cmd),
        .status   (status),
        .root     (m_axis_tdata)
    );

endmodule

FILE: src/isr_datapath.sv
// Datapath: remainder, partial root and trial bit registers with one subtract-compare unit.
module isr_datapath #(
    parameter int IN_WIDTH = 64
) (
    input  logic                            clk,
    input  logic [isr_pkg::RADICAND_W-1:0]  radicand,
    input  isr_pkg::isr_cmd_t               cmd,
    output isr_pkg::isr_status_t            status,
    output logic [isr_pkg::ROOT_W-1:0]      root
);
    import isr_pkg::*;

    // highest even bit position inside the datapath word
    localparam int TOP = ((IN_WIDTH - 1) / 2) * 2;

    logic [IN_WIDTH-1:0] rem_reg,  rem_next;
    logic [IN_WIDTH-1:0] root_reg, root_next;
    logic [IN_WIDTH-1:0] bit_reg,  bit_next;
    logic [ROOT_W-1:0]   result_reg, result_next;
    logic [IN_WIDTH:0]   trial;
    logic                fits;

    assign trial = {1'b0, root_reg} + {1'b0, bit_reg};
    assign fits  = {1'b0, rem_reg} >= trial;

    always_comb
    begin
        rem_next    = rem_reg;
        root_next   = root_reg;
        bit_next    = bit_reg;
        result_next = result_reg;
        if (cmd.load)
        begin
            rem_next  = radicand[IN_WIDTH-1:0];
            root_next = '0;
            bit_next  = IN_WIDTH'(1) << TOP;
        end
        else if (cmd.step)
        begin
            if (fits)
            begin
                rem_next  = rem_reg - trial[IN_WIDTH-1:0];
                root_next = (root_reg >> 1) + bit_reg;
            end
            else
            begin
                root_next = root_reg >> 1;
            end
            bit_next = bit_reg >> 2;
        end
        if (cmd.publish)
        begin
            result_next = ROOT_W'(root_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg    <= rem_next;
        root_reg   <= root_next;
        bit_reg    <= bit_next;
        result_reg <= result_next;
    end

    assign status.last_step = bit_reg[0];
    assign root             = result_reg;

endmodule

FILE: src/isr_ctrl.sv
// Controller: sequences load, iterations and result hand-off, owns both handshakes.
module isr_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    output logic                  out_valid,
    input  logic                  out_ready,
    input  isr_pkg::isr_status_t  status,
    output isr_pkg::isr_cmd_t     cmd
);
    import isr_pkg::*;

    isr_state_t state_reg, state_next;
    logic       out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        in_ready       = 1'b0;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_CALC;
                end
            end
            ST_CALC:
            begin
                cmd.step = 1'b1;
                if (status.last_step)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                // output register free, or its transaction completes now
                if (!out_valid_reg || out_ready)
                begin
                    cmd.publish    = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;

endmodule
